@@ hdl/psg_pkg.sv @@
`default_nettype none
package psg_pkg;

  localparam int unsigned PITCH_W = 16;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned AMP_W = 15;
  localparam int unsigned GAIN_W = 32;
  localparam int unsigned THRESH_W = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned SINE_W = 16;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW = 1;

  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOICING_THRESHOLD = 2'd2;

  localparam logic [AMP_W-1:0] AMPLITUDE_RST = 15'd5000;
  localparam logic [GAIN_W-1:0] STEP_GAIN_RST = 32'd274877907;
  localparam logic [THRESH_W-1:0] VOICING_THRESHOLD_RST = 16'd1;

  // Quarter turn in Q30.
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [PITCH_W-1:0] pitch;
    logic               unvoiced;
  } psg_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_EMIT
  } psg_state_t;

  // Quarter-wave table entry k in Q15, from a Taylor series up to x^13 in Q30.
  // Used only at elaboration to fill the table.
  function automatic logic [SINE_W-1:0] sine_q15_entry(input int unsigned k,
                                                      input int unsigned tbits);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    int unsigned     n;
    x = (HALF_PI_Q30 * longint'(k)) >> tbits;
    sum = longint'(x);
    term = x;
    for (n = 1; n <= 6; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      case (n)
        1: term = term / 6;
        2: term = term / 20;
        3: term = term / 42;
        4: term = term / 72;
        5: term = term / 110;
        default: term = term / 156;
      endcase
      if ((n & 1) != 0) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > 64'sd1073741824) sum = 64'sd1073741824;
    return SINE_W'((sum + 64'sd16384) >>> 15);
  endfunction

endpackage
`default_nettype wire

@@ hdl/psg_sine_rom.sv @@
`default_nettype none
module psg_sine_rom
  import psg_pkg::*;
#(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  wire logic                       clk,
  input  wire logic [SINE_TABLE_BITS:0]   rd_addr,
  output logic      [SINE_W-1:0]          rd_data_r
);

  localparam int unsigned ENTRIES = (1 << SINE_TABLE_BITS) + 1;

  logic [SINE_W-1:0] rom [ENTRIES];

  for (genvar k = 0; k < ENTRIES; k++) begin : g_entry
    localparam logic [SINE_W-1:0] VALUE = sine_q15_entry(k, SINE_TABLE_BITS);
    assign rom[k] = VALUE;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= rom[rd_addr];
  end

endmodule
`default_nettype wire

@@ hdl/psg_front.sv @@
`default_nettype none
module psg_front
  import psg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [PITCH_W-1:0]    in_pitch_hz,
  input  wire logic [THRESH_W-1:0]   voicing_threshold,
  output logic                       q_valid,
  output psg_item_t                  q_item,
  input  wire logic                  q_pop
);

  psg_item_t               entry_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]       count_r, count_nxt;
  logic                    push;
  psg_item_t               new_item;

  assign in_stall = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign push = in_valid && !in_stall;
  assign q_valid = (count_r != '0);
  assign q_item = entry_r[rd_ptr_r];

  // Classify at the door so the back end only sees a clear-phase flag.
  always_comb begin
    new_item.pitch = in_pitch_hz;
    new_item.unvoiced = (in_pitch_hz < voicing_threshold);
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt = count_r;
    if (push && !q_pop) count_nxt = count_r + 1'b1;
    else if (!push && q_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= new_item;
  end

endmodule
`default_nettype wire

@@ hdl/psg_back.sv @@
`default_nettype none
module psg_back
  import psg_pkg::*;
#(
  parameter int unsigned PHASE_BITS = 32,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_valid,
  input  wire psg_item_t                  q_item,
  output logic                            q_pop,
  input  wire logic [AMP_W-1:0]           amplitude,
  input  wire logic [GAIN_W-1:0]          step_gain,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [SAMPLE_W-1:0]      out_sample
);

  localparam int unsigned PROD_W = PITCH_W + GAIN_W;
  localparam int unsigned EXT_W = (PHASE_BITS + 16 > PROD_W) ? PHASE_BITS + 16 : PROD_W;

  psg_state_t                 state_r, state_nxt;
  logic [PHASE_BITS-1:0]      phase_r, phase_nxt;
  logic [PHASE_BITS-1:0]      base_r;
  logic [PHASE_BITS-1:0]      step_r;
  logic                       neg_r;
  logic [SAMPLE_W-1:0]        mag;
  logic [SAMPLE_W-1:0]        mag_r;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       load_out;

  logic [PHASE_BITS-1:0]      eff_phase;
  logic [1:0]                 quad;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [SINE_TABLE_BITS:0]   rom_addr;
  logic [SINE_W-1:0]          sine;
  logic [PROD_W-1:0]          prod;
  logic [EXT_W-1:0]           prod_ext;
  logic [AMP_W+SINE_W-1:0]    scaled;

  // An unvoiced word starts from phase zero; its own step is still added.
  assign eff_phase = q_item.unvoiced ? '0 : phase_r;
  assign quad = eff_phase[PHASE_BITS-1 -: 2];
  assign idx = eff_phase[PHASE_BITS-3 -: SINE_TABLE_BITS];
  assign rom_addr = quad[0] ? ({1'b1, {SINE_TABLE_BITS{1'b0}}} - {1'b0, idx})
                            : {1'b0, idx};

  assign prod = PROD_W'(q_item.pitch) * PROD_W'(step_gain);
  assign prod_ext = EXT_W'(prod);

  psg_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_rom (
    .clk      (clk),
    .rd_addr  (rom_addr),
    .rd_data_r(sine)
  );

  assign scaled = (AMP_W+SINE_W)'(amplitude) * (AMP_W+SINE_W)'(sine);
  assign mag = scaled[15 +: SAMPLE_W];
  assign load_out = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    q_pop = 1'b0;
    phase_nxt = phase_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        phase_nxt = base_r + step_r;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (load_out) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The table word for the popped item is only present in the scale cycle,
  // so the scaled magnitude is held until the output register takes it.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      base_r <= eff_phase;
      step_r <= prod_ext[16 +: PHASE_BITS];
      neg_r <= quad[1];
    end
    if (state_r == ST_SCALE) mag_r <= mag;
    if (load_out) out_sample_r <= neg_r ? -$signed(mag_r) : $signed(mag_r);
  end

  assign out_valid = out_valid_r;
  assign out_sample = out_sample_r;

endmodule
`default_nettype wire

@@ hdl/pitch_driven_sine_generator_core.sv @@
`default_nettype none
// Pitch-driven sine generator: a phase-accumulator oscillator with a quarter-wave table.
// Input channel: in_valid, in_stall, in_pitch_hz. Each word is one output-sample tick
// carrying the pitch in unsigned Q10.6 hertz. A word is taken at a clock edge where
// in_valid is high and in_stall is low.
// Result channel: out_valid, out_stall, out_sample. Every input word yields exactly one
// signed 16-bit sample, in order; it is taken where out_valid is high and out_stall low.
// Configuration: cfg_we, cfg_index, cfg_wdata write amplitude (0), step_gain (1) and
// voicing_threshold (2); other indexes are ignored. Write only while the block is idle.
// Sequencing: one word is worked on at a time by the back-end sequencer, which steps
// through pop and table lookup, scaling by amplitude, and loading of the output
// register. A two-word queue sits in front.
// When the receiver stalls, the finished sample is held and the back end waits; the
// queue still takes up to two more words before in_stall rises.
// Reset (synchronous, rst_n low) clears the phase, empties the queue, drops out_valid
// and restores the register defaults. The sine table is constant and needs no fill.
module pitch_driven_sine_generator_core
  import psg_pkg::*;
#(
  parameter int unsigned PHASE_BITS = 32,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [PITCH_W-1:0]        in_pitch_hz,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [SAMPLE_W-1:0]     out_sample,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_wdata
);

  logic [AMP_W-1:0]    amplitude_r;
  logic [GAIN_W-1:0]   step_gain_r;
  logic [THRESH_W-1:0] voicing_threshold_r;

  logic      q_valid;
  logic      q_pop;
  psg_item_t q_item;

  // Configuration registers, written one at a time by index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amplitude_r <= AMPLITUDE_RST;
      step_gain_r <= STEP_GAIN_RST;
      voicing_threshold_r <= VOICING_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AMPLITUDE:         amplitude_r <= cfg_wdata[AMP_W-1:0];
        REG_STEP_GAIN:         step_gain_r <= cfg_wdata[GAIN_W-1:0];
        REG_VOICING_THRESHOLD: voicing_threshold_r <= cfg_wdata[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: takes words, flags unvoiced ticks and queues them.
  psg_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pitch_hz      (in_pitch_hz),
    .voicing_threshold(voicing_threshold_r),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop)
  );

  // Back end: phase accumulator, table lookup, scaling and output register.
  psg_back #(
    .PHASE_BITS     (PHASE_BITS),
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .amplitude (amplitude_r),
    .step_gain (step_gain_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_sample(out_sample)
  );

  // The back end never pops an empty queue.
  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // A full front end always has a word waiting for the back end.
  a_stall_means_queued: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_valid)
    else $error("input stalled with an empty queue");

  // A popped word cannot reach the output in the very next cycle.
  a_pop_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && !out_valid) |=> !out_valid)
    else $error("result appeared too early after pop");

  // Reset leaves no result pending.
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

endmodule
`default_nettype wire
